// ===== src/gsi_pkg.sv =====
// Shared constants and codes for the gain schedule interpolator.
package gsi_pkg;

    localparam int DEF_MAX_POINTS  = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int DATA_W   = 32;   // Q16.16 breakpoints, gains and result
    localparam int IDX_W    = 4;
    localparam int CNT_W    = 5;
    localparam int REGION_W = 2;
    localparam int FRAC_W   = 16;   // fraction bits produced by the divider

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [REGION_W-1:0] REGION_INTERP = 2'd0;
    localparam logic [REGION_W-1:0] REGION_LOW    = 2'd1;
    localparam logic [REGION_W-1:0] REGION_HIGH   = 2'd2;

endpackage

// ===== src/gsi_ram.sv =====
// Generic single write port RAM with registered read.
module gsi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/gain_schedule_interpolator.sv =====
// Piecewise-linear gain schedule lookup: top level with search and divide sequencer.
//
// Input channel (i_in_valid / o_in_ready) takes one word per handshake. A word with
// opcode write stores a breakpoint/gain pair in the table and gives no result. A
// lookup word gives one result word on the output channel
// (o_out_valid / i_out_ready) carrying the gain and its region code.
// A lookup runs on one table read port and one restoring divider. A query clamped low or high
// takes its gain from an end entry; any other query runs a binary search for its interval,
// then, unless the interval is empty, the divider, which produces one fraction bit per cycle
// (16 bits), then a multiply and an add. The block takes no new word while a lookup is in
// progress, so lookups run one at a time. point_count is written through i_cfg_we /
// i_cfg_data; the user must do so only while the block is idle, which the block itself does
// not enforce; values below 2 act as 2 and values above MAX_POINTS as MAX_POINTS.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle, drops o_out_valid
// and sets point_count to 2. The table is not cleared: entries read before being
// written give undefined results.
// If the receiver stalls, the finished result waits in the output register and the
// sequencer holds in its last step until the output register is free.
module gain_schedule_interpolator
    import gsi_pkg::*;
#(
    parameter int MAX_POINTS  = DEF_MAX_POINTS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_opcode,
    input  logic [IDX_W-1:0]           i_entry_index,
    input  logic signed [DATA_W-1:0]   i_x_value,
    input  logic signed [DATA_W-1:0]   i_gain_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [DATA_W-1:0]   o_gain_out,
    output logic [REGION_W-1:0]        o_region,
    input  logic                       i_cfg_we,
    input  logic [CNT_W-1:0]           i_cfg_data
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int NW    = (CNT_W > AW + 1) ? CNT_W : AW + 1;
    localparam int EW    = (IDX_W > AW + 1) ? IDX_W : AW + 1;
    localparam int DW    = DATA_W + 1;               // differences of two table values
    localparam int PW    = FRAC_W + 1 + DW;          // fraction times gain difference
    localparam int SUM_W = (VALUE_WIDTH > DW) ? VALUE_WIDTH + 1 : DW + 1;
    localparam int CW    = $clog2(FRAC_W);

    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [3:0] {
        S_IDLE, S_FIRST, S_LAST, S_PROBE, S_CMP, S_LO, S_HI, S_DIV, S_MUL, S_ADD, S_OUT
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0]         r_point_count;
    logic signed [DATA_W-1:0] r_x,     n_x;
    logic [AW-1:0]            r_n_last, n_n_last;
    logic [AW-1:0]            r_lo,    n_lo;
    logic [AW-1:0]            r_hi,    n_hi;
    logic signed [DATA_W-1:0] r_bp_lo, n_bp_lo;
    logic signed [DATA_W-1:0] r_g_lo,  n_g_lo;
    logic signed [DW-1:0]     r_dg,    n_dg;
    logic [DW-1:0]            r_w,     n_w;
    logic [DW-1:0]            r_rem,   n_rem;
    logic [FRAC_W-1:0]        r_quo,   n_quo;
    logic [CW-1:0]            r_cnt,   n_cnt;
    logic signed [PW-1:0]     r_prod,  n_prod;
    logic signed [SUM_W-1:0]  r_acc,   n_acc;
    logic [REGION_W-1:0]      r_reg,   n_reg;
    logic                     r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_gain_out,  n_gain_out;
    logic [REGION_W-1:0]      r_region,    n_region;

    // table port
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic [2*DATA_W-1:0]      ram_rdata;
    logic signed [DATA_W-1:0] rd_bp, rd_g;
    logic [EW-1:0]            idx_e;

    logic                     in_fire;
    logic [NW-1:0]            pc_e, n_eff;
    logic [AW:0]              mid_sum;
    logic [AW-1:0]            mid, span;
    logic signed [DW-1:0]     w_s, dx_s, dg_s;
    logic [DW:0]              div_diff;
    logic signed [SUM_W-1:0]  acc_sat;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    assign idx_e     = EW'(i_entry_index);
    assign ram_we    = in_fire && (i_opcode == OP_WRITE) && (idx_e < EW'(MAX_POINTS));
    assign ram_waddr = idx_e[AW-1:0];

    assign rd_bp = ram_rdata[2*DATA_W-1:DATA_W];
    assign rd_g  = ram_rdata[DATA_W-1:0];

    gsi_ram #(
        .WIDTH(2 * DATA_W),
        .DEPTH(MAX_POINTS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata({i_x_value, i_gain_value}),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign pc_e  = NW'(r_point_count);
    assign n_eff = (pc_e < NW'(2)) ? NW'(2) :
                   (pc_e > NW'(MAX_POINTS)) ? NW'(MAX_POINTS) : pc_e;

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[AW:1];
    assign span    = r_hi - r_lo;

    assign w_s  = DW'(rd_bp) - DW'(r_bp_lo);
    assign dx_s = DW'(r_x) - DW'(r_bp_lo);
    assign dg_s = DW'(rd_g) - DW'(r_g_lo);

    // one restoring step: remainder stays below the interval width
    assign div_diff = {r_rem, 1'b0} - {1'b0, r_w};

    assign acc_sat = (r_acc > SAT_HI) ? SAT_HI : (r_acc < SAT_LO) ? SAT_LO : r_acc;

    // read address follows the step that consumes the data in the next cycle
    always_comb begin
        unique case (r_state)
            S_IDLE:  ram_raddr = '0;
            S_FIRST: ram_raddr = r_n_last;
            S_PROBE: ram_raddr = (span > AW'(1)) ? mid : r_lo;
            S_LO:    ram_raddr = r_hi;
            default: ram_raddr = r_lo;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_n_last    = r_n_last;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_bp_lo     = r_bp_lo;
        n_g_lo      = r_g_lo;
        n_dg        = r_dg;
        n_w         = r_w;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_reg       = r_reg;
        n_out_valid = r_out_valid && !i_out_ready;
        n_gain_out  = r_gain_out;
        n_region    = r_region;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire && (i_opcode == OP_LOOKUP)) begin
                    n_x      = i_x_value;
                    n_n_last = AW'(n_eff - NW'(1));
                    n_state  = S_FIRST;
                end
            end
            S_FIRST: begin
                if (r_x <= rd_bp) begin
                    n_acc   = SUM_W'(rd_g);
                    n_reg   = REGION_LOW;
                    n_state = S_OUT;
                end else begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                if (r_x >= rd_bp) begin
                    n_acc   = SUM_W'(rd_g);
                    n_reg   = REGION_HIGH;
                    n_state = S_OUT;
                end else begin
                    n_lo    = '0;
                    n_hi    = r_n_last;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                n_state = (span > AW'(1)) ? S_CMP : S_LO;
            end
            S_CMP: begin
                if (rd_bp <= r_x) begin
                    n_lo = mid;
                end else begin
                    n_hi = mid;
                end
                n_state = S_PROBE;
            end
            S_LO: begin
                n_bp_lo = rd_bp;
                n_g_lo  = rd_g;
                n_state = S_HI;
            end
            S_HI: begin
                n_dg = dg_s;
                if (w_s <= 0) begin
                    // empty interval: lower gain as is
                    n_acc   = SUM_W'(r_g_lo);
                    n_reg   = REGION_INTERP;
                    n_state = S_OUT;
                end else begin
                    n_w     = w_s;
                    n_rem   = dx_s;
                    n_quo   = '0;
                    n_cnt   = CW'(FRAC_W - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!div_diff[DW]) begin
                    n_rem = div_diff[DW-1:0];
                end else begin
                    n_rem = {r_rem[DW-2:0], 1'b0};
                end
                n_quo = {r_quo[FRAC_W-2:0], !div_diff[DW]};
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = $signed({1'b0, r_quo}) * r_dg;
                n_state = S_ADD;
            end
            S_ADD: begin
                // arithmetic shift floors the scaled product
                n_acc   = SUM_W'(r_g_lo) + SUM_W'($signed(r_prod[PW-1:FRAC_W]));
                n_reg   = REGION_INTERP;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_gain_out  = acc_sat[DATA_W-1:0];
                    n_region    = r_reg;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_point_count <= CNT_W'(2);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_point_count <= i_cfg_data;
            end
        end
        r_x        <= n_x;
        r_n_last   <= n_n_last;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_bp_lo    <= n_bp_lo;
        r_g_lo     <= n_g_lo;
        r_dg       <= n_dg;
        r_w        <= n_w;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_prod     <= n_prod;
        r_acc      <= n_acc;
        r_reg      <= n_reg;
        r_gain_out <= n_gain_out;
        r_region   <= n_region;
    end

    assign o_out_valid = r_out_valid;
    assign o_gain_out  = r_gain_out;
    assign o_region    = r_region;

endmodule

// ===== verif/gain_schedule_interpolator_tb.sv =====
// Self-checking testbench for the gain schedule interpolator: table loads, lookups, point counts.
`timescale 1ns / 100ps

module gain_schedule_interpolator_tb;
    import gsi_pkg::*;

    localparam int     MAX_PTS           = DEF_MAX_POINTS;
    localparam int     SETTLE_CYCLES     = 40;     // pause before point count writes and at the end of the run
    localparam int     CYCLE_LIMIT       = 1000000;
    localparam int     NUM_PHASES        = 17;
    localparam int     LOOKUPS_PER_PHASE = 84;
    localparam int     NUM_DIRECTED      = 25;
    localparam longint SAT_HI            = 64'sd2147483647;
    localparam longint SAT_LO            = -64'sd2147483648;

    localparam logic [CNT_W-1:0] COUNT_PLAN [8] = '{5'd16, 5'd31, 5'd2, 5'd9,
                                                    5'd17, 5'd0, 5'd5, 5'd1};

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;
    typedef enum logic [1:0] {ROW_WRITE, ROW_LOOKUP, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic [DATA_W-1:0]   gain;
        logic [REGION_W-1:0] region;
    } t_gain_result;

    typedef struct packed {
        t_row_kind           kind;
        logic [IDX_W-1:0]    idx;
        logic [DATA_W-1:0]   x;
        logic [DATA_W-1:0]   gain;
        logic [CNT_W-1:0]    count;
        logic                typed;
        logic [DATA_W-1:0]   exp_gain;
        logic [REGION_W-1:0] exp_region;
    } t_stim_row;

    // Table starts at bp -1.0 / +1.0 with extreme gains, then both ends equal at 0x5000.
    localparam t_stim_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{ROW_WRITE,  'h0, 32'hFFFF_0000, 32'h7FFF_FFFF, '0, 1'b0, '0, '0},
        '{ROW_WRITE,  'h1, 32'h0001_0000, 32'h8000_0000, '0, 1'b0, '0, '0},
        '{ROW_LOOKUP, 'h0, 32'h8000_0000, '0, '0, 1'b1, 32'h7FFF_FFFF, REGION_LOW},
        '{ROW_LOOKUP, 'hF, 32'h7FFF_FFFF, '1, '0, 1'b1, 32'h8000_0000, REGION_HIGH},
        '{ROW_LOOKUP, 'h3, 32'hFFFF_0000, '0, '0, 1'b1, 32'h7FFF_FFFF, REGION_LOW},
        '{ROW_LOOKUP, 'h0, 32'h0001_0000, '0, '0, 1'b1, 32'h8000_0000, REGION_HIGH},
        '{ROW_LOOKUP, 'h0, 32'h0000_0000, '0, '0, 1'b0, '0, '0},
        '{ROW_LOOKUP, 'h7, 32'h0000_FFFF, '0, '0, 1'b0, '0, '0},
        '{ROW_LOOKUP, 'h0, 32'hFFFF_0001, '0, '0, 1'b0, '0, '0},
        '{ROW_WRITE,  'h2, 32'h7FFF_FFFF, 32'h0001_2345, '0, 1'b0, '0, '0},
        '{ROW_WRITE,  'hF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, '0, 1'b0, '0, '0},
        '{ROW_CFG,    'h0, '0, '0, 5'd3, 1'b0, '0, '0},
        '{ROW_LOOKUP, 'h0, 32'h7FFF_FFFE, '0, '0, 1'b0, '0, '0},
        '{ROW_LOOKUP, 'h0, 32'h0001_0000, '0, '0, 1'b0, '0, '0},
        '{ROW_LOOKUP, 'h0, 32'h7FFF_FFFF, '0, '0, 1'b1, 32'h0001_2345, REGION_HIGH},
        '{ROW_CFG,    'h0, '0, '0, 5'd0, 1'b0, '0, '0},
        '{ROW_LOOKUP, 'h0, 32'h7FFF_FFFF, '0, '0, 1'b1, 32'h8000_0000, REGION_HIGH},
        '{ROW_CFG,    'h0, '0, '0, 5'd1, 1'b0, '0, '0},
        '{ROW_LOOKUP, 'h0, 32'h0000_0000, '0, '0, 1'b0, '0, '0},
        '{ROW_WRITE,  'h0, 32'h0000_5000, 32'h0000_0100, '0, 1'b0, '0, '0},
        '{ROW_WRITE,  'h1, 32'h0000_5000, 32'h0000_0200, '0, 1'b0, '0, '0},
        '{ROW_CFG,    'h0, '0, '0, 5'd2, 1'b0, '0, '0},
        '{ROW_LOOKUP, 'h0, 32'h0000_5000, '0, '0, 1'b1, 32'h0000_0100, REGION_LOW},
        '{ROW_LOOKUP, 'h0, 32'h0000_4FFF, '0, '0, 1'b1, 32'h0000_0100, REGION_LOW},
        '{ROW_LOOKUP, 'h0, 32'h0000_5001, '0, '0, 1'b1, 32'h0000_0200, REGION_HIGH}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_opcode;
    logic [IDX_W-1:0]    i_entry_index;
    logic [DATA_W-1:0]   i_x_value;
    logic [DATA_W-1:0]   i_gain_value;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [DATA_W-1:0]   o_gain_out;
    logic [REGION_W-1:0] o_region;
    logic                i_cfg_we;
    logic [CNT_W-1:0]    i_cfg_data;

    // shadow of the block state
    logic signed [DATA_W-1:0] bp_tab   [MAX_PTS];
    logic signed [DATA_W-1:0] gain_tab [MAX_PTS];
    logic [CNT_W-1:0]         point_cnt;

    t_gain_result pending_gains[$];
    t_idle_mode   idle_mode = IDLE_NONE;
    int           fail_cnt  = 0;
    int           cycle_cnt = 0;

    gain_schedule_interpolator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_entry_index (i_entry_index),
        .i_x_value     (i_x_value),
        .i_gain_value  (i_gain_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_gain_out    (o_gain_out),
        .o_region      (o_region),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("gain_schedule_interpolator_tb failed");
            $finish;
        end
    end

    function automatic int active_points();
        int n;
        n = point_cnt;
        if (n < 2) n = 2;
        if (n > MAX_PTS) n = MAX_PTS;
        return n;
    endfunction

    // Clamp at the ends, else bisect and interpolate with a Q0.16 fraction.
    function automatic t_gain_result interpolate_gain(logic signed [DATA_W-1:0] query);
        t_gain_result res;
        int           n, lo, hi, mid;
        longint       q, w, dx, frac, dg, sum;
        q = query;
        n = active_points();
        if (q <= longint'(bp_tab[0])) begin
            res.gain   = gain_tab[0];
            res.region = REGION_LOW;
        end else if (q >= longint'(bp_tab[n-1])) begin
            res.gain   = gain_tab[n-1];
            res.region = REGION_HIGH;
        end else begin
            lo = 0;
            hi = n - 1;
            while (hi - lo > 1) begin
                mid = (lo + hi) / 2;
                if (longint'(bp_tab[mid]) <= q) lo = mid;
                else hi = mid;
            end
            res.region = REGION_INTERP;
            w = longint'(bp_tab[hi]) - longint'(bp_tab[lo]);
            if (w <= 0) begin
                res.gain = gain_tab[lo];
            end else begin
                dx = q - longint'(bp_tab[lo]);
                if (dx < 0) dx = 0;
                frac = (dx <<< FRAC_W) / w;
                if (frac > 65535) frac = 65535;
                dg  = longint'(gain_tab[hi]) - longint'(gain_tab[lo]);
                sum = longint'(gain_tab[lo]) + ((frac * dg) >>> FRAC_W);   // floor
                if (sum > SAT_HI) sum = SAT_HI;
                if (sum < SAT_LO) sum = SAT_LO;
                res.gain = sum[DATA_W-1:0];
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] want,
                                   logic [DATA_W-1:0] got);
        $display("MISMATCH %s: expected %h got %h at cycle %0d", what, want, got, cycle_cnt);
        fail_cnt++;
    endtask

    // Called right after a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(logic op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] xv,
                             logic [DATA_W-1:0] gv, logic typed, t_gain_result fixed_res);
        i_in_valid    = 1'b1;
        i_opcode      = op;
        i_entry_index = idx;
        i_x_value     = xv;
        i_gain_value  = gv;
        do @(posedge i_clk); while (!o_in_ready);
        if (op == OP_WRITE) begin
            bp_tab[idx]   = xv;
            gain_tab[idx] = gv;
        end else begin
            pending_gains.push_back(typed ? fixed_res : interpolate_gain(xv));
        end
        @(negedge i_clk);
    endtask

    task automatic sender_gap();
        int pct;
        pct = (idle_mode == IDLE_SEND) ? 56 : (idle_mode == IDLE_BOTH) ? 23 : 0;
        while ($urandom_range(0, 99) < pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid = 1'b0;
        while (pending_gains.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_point_count(logic [CNT_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we  = 1'b0;
        point_cnt = value;
    endtask

    function automatic logic [DATA_W-1:0] random_gain();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        return $urandom;
    endfunction

    // Mostly ascending tables with spacing from 1 up to 2^27; some scrambled or with repeats.
    task automatic load_table();
        longint bp_new [MAX_PTS];
        longint step_cap, base;
        int     style, ofs, i, k;
        style    = $urandom_range(0, 9);
        step_cap = longint'(1) << $urandom_range(0, 27);
        base     = longint'($urandom) % ((longint'(1) << 32) - 15 * step_cap)
                   - (longint'(1) << 31);
        for (i = 0; i < MAX_PTS; i++) begin
            if (style == 0)
                bp_new[i] = longint'(int'($urandom));
            else if (i == 0)
                bp_new[i] = base;
            else if (style == 1 && $urandom_range(0, 2) == 0)
                bp_new[i] = bp_new[i-1];
            else
                bp_new[i] = bp_new[i-1] + 1 + longint'($urandom) % step_cap;
        end
        ofs = $urandom_range(0, MAX_PTS - 1);
        for (i = 0; i < MAX_PTS; i++) begin
            k = (i + ofs) % MAX_PTS;
            sender_gap();
            send_word(OP_WRITE, k[IDX_W-1:0], bp_new[k][DATA_W-1:0], random_gain(),
                      1'b0, '0);
        end
    endtask

    always @(negedge i_clk) begin
        case (idle_mode)
            IDLE_RECV: i_out_ready <= ($urandom_range(0, 99) >= 56);
            IDLE_BOTH: i_out_ready <= ($urandom_range(0, 99) >= 23);
            default:   i_out_ready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin : result_check
        t_gain_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_gains.size() == 0) begin
                report_mismatch("result word with nothing pending", '0, o_gain_out);
            end else begin
                want = pending_gains.pop_front();
                if (o_gain_out !== want.gain)
                    report_mismatch("gain_out", want.gain, o_gain_out);
                if (o_region !== want.region)
                    report_mismatch("region", DATA_W'(want.region), DATA_W'(o_region));
            end
        end
    end

    initial begin
        t_stim_row         row;
        int                r, phase, i, n_eff, k;
        longint            q, lo_bp, hi_bp;
        logic [DATA_W-1:0] query;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_opcode      = OP_WRITE;
        i_entry_index = '0;
        i_x_value     = '0;
        i_gain_value  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        point_cnt     = 5'd2;
        for (i = 0; i < MAX_PTS; i++) begin
            bp_tab[i]   = '0;
            gain_tab[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (r = 0; r < NUM_DIRECTED; r++) begin
            row = DIRECTED_ROWS[r];
            case (row.kind)
                ROW_CFG:   write_point_count(row.count);
                ROW_WRITE: send_word(OP_WRITE, row.idx, row.x, row.gain, 1'b0, '0);
                default:   send_word(OP_LOOKUP, row.idx, row.x, row.gain, row.typed,
                                     t_gain_result'({row.exp_gain, row.exp_region}));
            endcase
        end

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            write_point_count(phase < 8 ? COUNT_PLAN[phase] : CNT_W'($urandom_range(0, 31)));
            idle_mode = t_idle_mode'(phase % 4);
            load_table();
            for (i = 0; i < LOOKUPS_PER_PHASE; i++) begin
                if (phase == 5 && i == 30) drain_results();
                sender_gap();
                if ($urandom_range(0, 99) < 8) begin
                    // gain rewrite that keeps the breakpoint in place
                    k = $urandom_range(0, MAX_PTS - 1);
                    send_word(OP_WRITE, k[IDX_W-1:0], bp_tab[k], random_gain(), 1'b0, '0);
                end else begin
                    n_eff = active_points();
                    lo_bp = bp_tab[0];
                    hi_bp = bp_tab[n_eff-1];
                    k     = $urandom_range(0, n_eff - 1);
                    case ($urandom_range(0, 9))
                        0: q = bp_tab[k];
                        1: q = longint'(bp_tab[k]) + $urandom_range(0, 6) - 3;
                        2: q = longint'(int'($urandom));
                        3: q = $urandom_range(0, 1) ? SAT_HI : SAT_LO;
                        default: begin
                            if (hi_bp > lo_bp)
                                q = lo_bp + longint'($urandom) % (hi_bp - lo_bp + 1);
                            else
                                q = longint'(int'($urandom));
                        end
                    endcase
                    if (q > SAT_HI) q = SAT_HI;
                    if (q < SAT_LO) q = SAT_LO;
                    query = q[DATA_W-1:0];
                    send_word(OP_LOOKUP, IDX_W'($urandom_range(0, MAX_PTS - 1)), query,
                              $urandom, 1'b0, '0);
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_cnt == 0)
            $display("gain_schedule_interpolator_tb passed");
        else
            $display("gain_schedule_interpolator_tb failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/gsi_pkg.sv
src/gsi_ram.sv
src/gain_schedule_interpolator.sv
verif/gain_schedule_interpolator_tb.sv
